// ===== rtl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Circular stack engine package
// Field widths, request codes and status codes shared by the engine and its
// channel interfaces.
// ----------------------------------------------------------------------------
package cse_pkg;

   localparam int REQ_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [REQ_W-1:0] {
      OP_PUSH       = 3'd0,
      OP_POP        = 3'd1,
      OP_ROTATE     = 3'd2,
      OP_REV_ROTATE = 3'd3,
      OP_SWAP       = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_FEW   = 2'd3
   } status_type;

endpackage

// ===== rtl/cse_req_if.sv =====
// ----------------------------------------------------------------------------
// Circular stack engine request channel
// Valid/ready channel carrying one request beat.
// ----------------------------------------------------------------------------
interface cse_req_if;

   logic                              valid;
   logic                              ready;
   logic        [cse_pkg::REQ_W-1:0]   req_type;
   logic signed [cse_pkg::VALUE_W-1:0] push_value;

   modport source (output valid, output req_type, output push_value, input ready);
   modport sink   (input valid, input req_type, input push_value, output ready);

endinterface

// ===== rtl/cse_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Circular stack engine response channel
// Valid/ready channel carrying one response beat.
// ----------------------------------------------------------------------------
interface cse_rsp_if;

   logic                                valid;
   logic                                ready;
   logic signed [cse_pkg::VALUE_W-1:0]  popped_value;
   logic        [cse_pkg::STATUS_W-1:0] status;
   logic signed [cse_pkg::VALUE_W-1:0]  top_value;
   logic        [cse_pkg::COUNT_W-1:0]  entry_count;

   modport source (output valid, output popped_value, output status, output top_value,
                   output entry_count, input ready);
   modport sink   (input valid, input popped_value, input status, input top_value,
                   input entry_count, output ready);

endinterface

// ===== rtl/cse_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/circular_stack_engine.sv =====
// A request beat, once accepted, passes the execute stage and then the result register.
// Throughput: one request per cycle unless rsp_chan stalls; one RAM read and write each.
// Reset: synchronous; empties the stack with no clearing pass over the RAM.
// Ring entries are undefined until written; an unwritten entry may be read but never reaches a response.
// ----------------------------------------------------------------------------
// Circular stack engine
// Bounded circular stack with push, pop, rotate, reverse rotate and swap. The
// top entry lives in a register and the rest of the ring in a RAM.
// ----------------------------------------------------------------------------
module circular_stack_engine #(
   parameter int STACK_DEPTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   cse_req_if.sink   req_chan,
   cse_rsp_if.source rsp_chan
);

   localparam int PTR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int VAL_W = cse_pkg::VALUE_W;

   typedef enum logic [1:0] {
      TOP_KEEP,
      TOP_PUSH,
      TOP_READ
   } top_sel_type;

   function automatic logic [PTR_W-1:0] pos_add(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] k);
      logic [SUM_W-1:0] s;
      s = SUM_W'(p) + SUM_W'(k);
      if (s >= SUM_W'(STACK_DEPTH)) begin
         s = s - SUM_W'(STACK_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(STACK_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] pos_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(STACK_DEPTH - 1) : p - 1'b1;
   endfunction

   // Pointer state, updated as each request beat is accepted.
   logic [PTR_W-1:0] top_pos_ff, top_pos_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Execute stage.
   logic                          s1_valid_ff, s1_valid_in;
   top_sel_type                   s1_top_sel_ff, s1_top_sel_in;
   cse_pkg::status_type           s1_status_ff, s1_status_in;
   logic                          s1_pop_ff, s1_pop_in;
   logic [CNT_W-1:0]              s1_count_ff;
   logic                          s1_wr_en_ff, s1_wr_en_in;
   logic [PTR_W-1:0]              s1_wr_addr_ff, s1_wr_addr_in;
   logic [PTR_W-1:0]              s1_rd_addr_ff, s1_rd_addr_in;
   logic [VAL_W-1:0]              s1_push_value_ff;

   // Write forwarded from the previous request over the RAM read.
   logic                          fwd_valid_ff, fwd_valid_in;
   logic [PTR_W-1:0]              fwd_addr_ff;
   logic [VAL_W-1:0]              fwd_data_ff;

   logic [VAL_W-1:0]              top_value_ff, top_value_in;

   // Result register.
   logic                          out_valid_ff, out_valid_in;
   logic [VAL_W-1:0]              out_popped_ff, out_popped_in;
   logic [cse_pkg::STATUS_W-1:0]  out_status_ff;
   logic [VAL_W-1:0]              out_top_ff, out_top_in;
   logic [cse_pkg::COUNT_W-1:0]   out_count_ff;

   logic                          accept;
   logic                          s1_advance;
   logic                          is_empty;
   logic                          is_full;
   logic                          is_single;
   logic [PTR_W-1:0]              top_next_pos;
   logic [PTR_W-1:0]              top_prev_pos;
   logic [VAL_W-1:0]              ram_rd_data;
   logic [VAL_W-1:0]              read_value;

   assign s1_advance     = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_empty     = (count_ff == '0);
   assign is_full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign is_single    = (count_ff == CNT_W'(1));
   assign top_next_pos = pos_inc(top_pos_ff);
   assign top_prev_pos = pos_dec(top_pos_ff);

   always_comb begin
      top_pos_in    = top_pos_ff;
      count_in      = count_ff;
      s1_top_sel_in = TOP_KEEP;
      s1_status_in  = cse_pkg::ST_DONE;
      s1_pop_in     = 1'b0;
      s1_wr_en_in   = 1'b0;
      s1_wr_addr_in = top_pos_ff;
      s1_rd_addr_in = top_next_pos;
      case (req_chan.req_type)
         cse_pkg::OP_PUSH: begin
            if (is_full) begin
               s1_status_in = cse_pkg::ST_FULL;
            end else begin
               top_pos_in    = top_prev_pos;
               count_in      = count_ff + 1'b1;
               s1_wr_en_in   = !is_empty;
               s1_top_sel_in = TOP_PUSH;
            end
         end
         cse_pkg::OP_POP: begin
            if (is_empty) begin
               s1_status_in = cse_pkg::ST_EMPTY;
            end else begin
               top_pos_in    = top_next_pos;
               count_in      = count_ff - 1'b1;
               s1_pop_in     = 1'b1;
               s1_top_sel_in = TOP_READ;
            end
         end
         cse_pkg::OP_ROTATE: begin
            if (is_empty) begin
               s1_status_in = cse_pkg::ST_EMPTY;
            end else begin
               top_pos_in    = top_next_pos;
               s1_wr_en_in   = 1'b1;
               s1_wr_addr_in = pos_add(top_pos_ff, count_ff);
               s1_top_sel_in = is_single ? TOP_KEEP : TOP_READ;
            end
         end
         cse_pkg::OP_REV_ROTATE: begin
            if (is_empty) begin
               s1_status_in = cse_pkg::ST_EMPTY;
            end else begin
               top_pos_in    = top_prev_pos;
               s1_wr_en_in   = 1'b1;
               s1_rd_addr_in = pos_add(top_pos_ff, count_ff - 1'b1);
               s1_top_sel_in = is_single ? TOP_KEEP : TOP_READ;
            end
         end
         cse_pkg::OP_SWAP: begin
            if (is_empty || is_single) begin
               s1_status_in = cse_pkg::ST_FEW;
            end else begin
               s1_wr_en_in   = 1'b1;
               s1_wr_addr_in = top_next_pos;
               s1_top_sel_in = TOP_READ;
            end
         end
         default: begin
         end
      endcase
   end

   // The top entry is held in a register; whenever it stops being the top it
   // is written back to its place in the ring, unless it was popped.
   cse_ram #(
      .WIDTH (VAL_W),
      .DEPTH (STACK_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_advance && s1_wr_en_ff),
      .wr_addr (s1_wr_addr_ff),
      .wr_data (top_value_ff),
      .rd_en   (accept),
      .rd_addr (s1_rd_addr_in),
      .rd_data (ram_rd_data)
   );

   assign read_value = (fwd_valid_ff && (fwd_addr_ff == s1_rd_addr_ff)) ? fwd_data_ff
                                                                        : ram_rd_data;

   always_comb begin
      case (s1_top_sel_ff)
         TOP_PUSH: top_value_in = s1_push_value_ff;
         TOP_READ: top_value_in = read_value;
         default:  top_value_in = top_value_ff;
      endcase
   end

   assign s1_valid_in   = accept || (s1_valid_ff && !s1_advance);
   assign fwd_valid_in  = s1_advance && s1_wr_en_ff;
   assign out_valid_in  = s1_advance || (out_valid_ff && !rsp_chan.ready);
   assign out_popped_in = s1_pop_ff ? top_value_ff : '0;
   assign out_top_in    = (s1_count_ff != '0) ? top_value_in : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_pos_ff   <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            top_pos_ff   <= top_pos_in;
            count_ff     <= count_in;
            fwd_valid_ff <= fwd_valid_in;
         end
      end
      if (accept) begin
         s1_top_sel_ff    <= s1_top_sel_in;
         s1_status_ff     <= s1_status_in;
         s1_pop_ff        <= s1_pop_in;
         s1_count_ff      <= count_in;
         s1_wr_en_ff      <= s1_wr_en_in;
         s1_wr_addr_ff    <= s1_wr_addr_in;
         s1_rd_addr_ff    <= s1_rd_addr_in;
         s1_push_value_ff <= req_chan.push_value;
         fwd_addr_ff      <= s1_wr_addr_ff;
         fwd_data_ff      <= top_value_ff;
      end
      if (s1_advance) begin
         top_value_ff  <= top_value_in;
         out_popped_ff <= out_popped_in;
         out_status_ff <= s1_status_ff;
         out_top_ff    <= out_top_in;
         out_count_ff  <= cse_pkg::COUNT_W'(s1_count_ff);
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.popped_value = out_popped_ff;
   assign rsp_chan.status       = out_status_ff;
   assign rsp_chan.top_value    = out_top_ff;
   assign rsp_chan.entry_count  = out_count_ff;

endmodule
